>>> sv/assert_macros.svh
// Concurrent assertion helpers; the using module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SKVB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SKVB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SKVB_ASSERT(lbl, prop, msg)
`define SKVB_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

>>> sv/skvb_pkg.sv
package skvb_pkg;

  localparam int SKVB_DEPTH      = 64;
  localparam int SKVB_KEY_BITS   = 32;
  localparam int SKVB_VALUE_BITS = 32;
  localparam int CFG_BITS        = 7;
  localparam int ACTION_BITS     = 3;
  localparam int STATUS_BITS     = 2;

  localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RESET = 7'd64;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_PUT    = 3'd0,
    ACT_GET    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_RANGE  = 3'd3,
    ACT_FLUSH  = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_DEL,
    S_LIST,
    S_RESP
  } state_t;

endpackage

>>> sv/skvb_if.sv
interface skvb_cmd_if import skvb_pkg::*; #(
  parameter int KEY_BITS   = SKVB_KEY_BITS,
  parameter int VALUE_BITS = SKVB_VALUE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [ACTION_BITS-1:0] action;
  logic [KEY_BITS-1:0]    key;
  logic [KEY_BITS-1:0]    end_key;
  logic [VALUE_BITS-1:0]  value;

  modport source (output valid, action, key, end_key, value, input ready);
  modport sink   (input valid, action, key, end_key, value, output ready);
endinterface

interface skvb_rsp_if import skvb_pkg::*; #(
  parameter int KEY_BITS   = SKVB_KEY_BITS,
  parameter int VALUE_BITS = SKVB_VALUE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [KEY_BITS-1:0]    out_key;
  logic [VALUE_BITS-1:0]  out_value;
  logic                   last;

  modport source (output valid, status, out_key, out_value, last, input ready);
  modport sink   (input valid, status, out_key, out_value, last, output ready);
endinterface

>>> sv/skvb_ram.sv
module skvb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sorted_kv_buffer_top.sv
// Channel  Dir  Payload                             Accepted when
// cmd      in   action, key, end_key, value         valid && ready
// rsp      out  status, out_key, out_value, last    valid && ready
// cfg      in   cfg_data (max_entries)              cfg_we
//
// One command at a time; entries live in one RAM, one entry per cycle.
// Get, put, remove, range and flush walk the entries in key order, so their time
// grows with the entry count (range/flush also with output stalls); the single RAM read port sets the walk.
// Reset empties the buffer at once (entry count to zero), no clearing pass.
// A stalled rsp holds the walk; cmd is taken only between commands.
`include "assert_macros.svh"
module sorted_kv_buffer_top import skvb_pkg::*; #(
  parameter int DEPTH      = SKVB_DEPTH,
  parameter int KEY_BITS   = SKVB_KEY_BITS,
  parameter int VALUE_BITS = SKVB_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  skvb_cmd_if.sink            cmd,
  skvb_rsp_if.source          rsp
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + VALUE_BITS;
  localparam logic [CW-1:0]       ONE    = CW'(1);
  localparam logic [CFG_BITS-1:0] DEPTHC = CFG_BITS'(DEPTH);

  state_t state, state_next;
  action_t act, act_next;
  logic [KEY_BITS-1:0]   k, k_next, ek, ek_next;
  logic [VALUE_BITS-1:0] v, v_next;
  logic [CW-1:0] count, count_next, idx, idx_next, pos, pos_next;
  logic [CFG_BITS-1:0] max_entries;
  logic pend_valid, pend_valid_next;
  logic [KEY_BITS-1:0]   pend_key, pend_key_next;
  logic [VALUE_BITS-1:0] pend_val, pend_val_next;
  status_t resp_status, resp_status_next;
  logic [VALUE_BITS-1:0] resp_value, resp_value_next;
  logic ov, ov_next, o_last, o_last_next;
  status_t o_status, o_status_next;
  logic [KEY_BITS-1:0]   o_key, o_key_next;
  logic [VALUE_BITS-1:0] o_value, o_value_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  logic full, in_range, scan_stop, hit, list_take, out_free;

  skvb_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign rd_key    = ram_rdata[EW-1:VALUE_BITS];
  assign rd_val    = ram_rdata[VALUE_BITS-1:0];
  assign full      = CFG_BITS'(count) >= ((max_entries > DEPTHC) ? DEPTHC : max_entries);
  assign in_range  = idx < count;
  assign scan_stop = !in_range || (rd_key >= k);
  assign hit       = in_range && (rd_key == k);
  assign list_take = in_range && !((act == ACT_RANGE) && (rd_key > ek));
  assign out_free  = !ov || rsp.ready;

  assign cmd.ready     = (state == S_IDLE);
  assign rsp.valid     = ov;
  assign rsp.status    = o_status;
  assign rsp.out_key   = o_key;
  assign rsp.out_value = o_value;
  assign rsp.last      = o_last;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          unique case (cmd.action)
            ACT_PUT:                       state_next = full ? S_RESP : S_SCAN;
            ACT_GET, ACT_REMOVE, ACT_RANGE: state_next = S_SCAN;
            ACT_FLUSH:                     state_next = S_LIST;
            ACT_CLEAR:                     state_next = S_RESP;
            default:                       state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          unique case (act)
            ACT_PUT:    state_next = hit ? S_RESP : S_INS;
            ACT_REMOVE: state_next = hit ? S_DEL : S_RESP;
            ACT_RANGE:  state_next = S_LIST;
            default:    state_next = S_RESP;
          endcase
        end
      end
      S_INS:  if (idx == pos) state_next = S_RESP;
      S_DEL:  if (idx + ONE == count) state_next = S_RESP;
      S_LIST: if (!list_take && out_free) state_next = S_IDLE;
      S_RESP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    act_next         = act;
    k_next           = k;
    ek_next          = ek;
    v_next           = v;
    count_next       = count;
    idx_next         = idx;
    pos_next         = pos;
    pend_valid_next  = pend_valid;
    pend_key_next    = pend_key;
    pend_val_next    = pend_val;
    resp_status_next = resp_status;
    resp_value_next  = resp_value;
    ov_next          = ov && !rsp.ready;
    o_status_next    = o_status;
    o_key_next       = o_key;
    o_value_next     = o_value;
    o_last_next      = o_last;
    ram_we           = 1'b0;
    ram_waddr        = idx[AW-1:0];
    ram_wdata        = {k, v};
    ram_raddr        = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          act_next         = action_t'(cmd.action);
          k_next           = cmd.key;
          ek_next          = cmd.end_key;
          v_next           = cmd.value;
          idx_next         = '0;
          ram_raddr        = '0;
          pend_valid_next  = 1'b0;
          resp_status_next = (cmd.action == ACT_PUT && full) ? ST_FULL : ST_OK;
          resp_value_next  = '0;
          if (cmd.action == ACT_CLEAR) begin
            count_next = '0;
          end
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          pos_next = idx;
          unique case (act)
            ACT_PUT: begin
              if (hit) begin
                ram_we = 1'b1;
              end else begin
                idx_next  = count;
                ram_raddr = AW'(count - ONE);
              end
            end
            ACT_GET: begin
              resp_status_next = hit ? ST_OK : ST_MISS;
              resp_value_next  = hit ? rd_val : '0;
            end
            ACT_REMOVE: begin
              resp_status_next = hit ? ST_OK : ST_MISS;
              ram_raddr        = AW'(idx + ONE);
            end
            default: ;
          endcase
        end else begin
          idx_next  = idx + ONE;
          ram_raddr = AW'(idx + ONE);
        end
      end
      S_INS: begin
        // shift the tail up one slot, top entry first, then drop the new one in
        ram_we = 1'b1;
        if (idx == pos) begin
          count_next = count + ONE;
        end else begin
          ram_wdata = ram_rdata;
          idx_next  = idx - ONE;
          ram_raddr = AW'(idx - ONE - ONE);
        end
      end
      S_DEL: begin
        if (idx + ONE == count) begin
          count_next = count - ONE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          idx_next  = idx + ONE;
          ram_raddr = AW'(idx + ONE + ONE);
        end
      end
      S_LIST: begin
        // hold one entry back so last can be set on the final one
        if (list_take) begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              ov_next       = 1'b1;
              o_status_next = ST_OK;
              o_key_next    = pend_key;
              o_value_next  = pend_val;
              o_last_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_key_next   = rd_key;
            pend_val_next   = rd_val;
            idx_next        = idx + ONE;
            ram_raddr       = AW'(idx + ONE);
          end
        end else if (out_free) begin
          ov_next       = 1'b1;
          o_status_next = pend_valid ? ST_OK : ST_MISS;
          o_key_next    = pend_valid ? pend_key : '0;
          o_value_next  = pend_valid ? pend_val : '0;
          o_last_next   = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_next       = 1'b1;
          o_status_next = resp_status;
          o_key_next    = '0;
          o_value_next  = resp_value;
          o_last_next   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      max_entries <= MAX_ENTRIES_RESET;
      ov          <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ov         <= ov_next;
      pend_valid <= pend_valid_next;
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act         <= act_next;
    k           <= k_next;
    ek          <= ek_next;
    v           <= v_next;
    idx         <= idx_next;
    pos         <= pos_next;
    pend_key    <= pend_key_next;
    pend_val    <= pend_val_next;
    resp_status <= resp_status_next;
    resp_value  <= resp_value_next;
    o_status    <= o_status_next;
    o_key       <= o_key_next;
    o_value     <= o_value_next;
    o_last      <= o_last_next;
  end

  `SKVB_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `SKVB_ASSERT_IMPL(a_we_busy, ram_we, state == S_SCAN || state == S_INS || state == S_DEL, "RAM write outside update")
  `SKVB_ASSERT_IMPL(a_count_step, count != $past(count), count == $past(count) + ONE || count == $past(count) - ONE || count == '0, "entry count jumped")
  `SKVB_ASSERT_IMPL(a_list_idx, state == S_LIST, idx <= count, "list walk past end")
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import skvb_pkg::*;

  localparam logic [ACTION_BITS-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED_HI = 3'd7;
  localparam int IDLE_SETTLE = 2 * SKVB_DEPTH + 20;

  typedef struct {
    status_t     status;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic        last;
  } rsp_item_t;

  typedef struct {
    logic [ACTION_BITS-1:0] action;
    logic [31:0]            key;
    logic [31:0]            end_key;
    logic [31:0]            value;
    bit                     typed;
    status_t                typed_status;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  skvb_cmd_if cmd_if ();
  skvb_rsp_if rsp_if ();

  sorted_kv_buffer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd_if),
    .rsp      (rsp_if)
  );

  always #6 clk = ~clk;

  // shadow copy of the buffer
  logic [31:0] shadow_keys [SKVB_DEPTH];
  logic [31:0] shadow_vals [SKVB_DEPTH];
  int          shadow_count;
  int          shadow_limit;
  rsp_item_t   pending_rsp [$];
  int          error_count = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  int          recv_hold = 0;

  function automatic rsp_item_t mk_rsp(status_t st, logic [31:0] k, logic [31:0] v, logic l);
    rsp_item_t r;
    r.status = st;
    r.out_key = k;
    r.out_value = v;
    r.last = l;
    return r;
  endfunction

  function automatic int find_slot(logic [31:0] k);
    int i;
    i = 0;
    while (i < shadow_count && shadow_keys[i] < k) i++;
    return i;
  endfunction

  // update the shadow buffer and queue the answers of one command
  function automatic void model_command(logic [ACTION_BITS-1:0] act, logic [31:0] k,
                                        logic [31:0] ek, logic [31:0] v);
    int lim;
    int pos;
    int n;
    lim = (shadow_limit > SKVB_DEPTH) ? SKVB_DEPTH : shadow_limit;
    case (act)
      ACT_PUT: begin
        if (shadow_count >= lim) begin
          pending_rsp.push_back(mk_rsp(ST_FULL, '0, '0, 1'b1));
        end else begin
          pos = find_slot(k);
          if (pos < shadow_count && shadow_keys[pos] == k) begin
            shadow_vals[pos] = v;
          end else begin
            for (int i = shadow_count; i > pos; i--) begin
              shadow_keys[i] = shadow_keys[i-1];
              shadow_vals[i] = shadow_vals[i-1];
            end
            shadow_keys[pos] = k;
            shadow_vals[pos] = v;
            shadow_count++;
          end
          pending_rsp.push_back(mk_rsp(ST_OK, '0, '0, 1'b1));
        end
      end
      ACT_GET: begin
        pos = find_slot(k);
        if (pos < shadow_count && shadow_keys[pos] == k)
          pending_rsp.push_back(mk_rsp(ST_OK, '0, shadow_vals[pos], 1'b1));
        else
          pending_rsp.push_back(mk_rsp(ST_MISS, '0, '0, 1'b1));
      end
      ACT_REMOVE: begin
        pos = find_slot(k);
        if (pos < shadow_count && shadow_keys[pos] == k) begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          shadow_count--;
          pending_rsp.push_back(mk_rsp(ST_OK, '0, '0, 1'b1));
        end else begin
          pending_rsp.push_back(mk_rsp(ST_MISS, '0, '0, 1'b1));
        end
      end
      ACT_RANGE, ACT_FLUSH: begin
        pos = (act == ACT_RANGE) ? find_slot(k) : 0;
        n = 0;
        for (int i = pos; i < shadow_count; i++) begin
          if (act == ACT_RANGE && shadow_keys[i] > ek) break;
          pending_rsp.push_back(mk_rsp(ST_OK, shadow_keys[i], shadow_vals[i],
                                       (i == shadow_count - 1) ? 1'b1 : 1'b0));
          n++;
        end
        if (n == 0)
          pending_rsp.push_back(mk_rsp(ST_MISS, '0, '0, 1'b1));
        else
          pending_rsp[$].last = 1'b1;
      end
      ACT_CLEAR: begin
        shadow_count = 0;
        pending_rsp.push_back(mk_rsp(ST_OK, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 23) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // present one item at the falling edge and hold it until taken
  task automatic send_cmd(cmd_row_t row);
    int gap;
    int pre;
    gap = draw_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid = 1'b1;
    cmd_if.action = row.action;
    cmd_if.key = row.key;
    cmd_if.end_key = row.end_key;
    cmd_if.value = row.value;
    do @(posedge clk); while (!cmd_if.ready);
    pre = pending_rsp.size();
    model_command(row.action, row.key, row.end_key, row.value);
    if (row.typed) begin
      while (pending_rsp.size() > pre) void'(pending_rsp.pop_back());
      pending_rsp.push_back(mk_rsp(row.typed_status, '0, '0, 1'b1));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(int lim);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = lim[CFG_BITS-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_limit = lim;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic cmd_row_t random_cmd();
    cmd_row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.action = ACT_PUT;
    else if (pick < 60) r.action = ACT_GET;
    else if (pick < 78) r.action = ACT_REMOVE;
    else if (pick < 90) r.action = ACT_RANGE;
    else if (pick < 94) r.action = ACT_FLUSH;
    else if (pick < 97) r.action = ACT_CLEAR;
    else r.action = $urandom_range(0, 1) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
    r.key = pick_key();
    r.end_key = $urandom_range(0, 3) == 0 ? $urandom : r.key + $urandom_range(0, 20);
    r.value = $urandom;
    r.typed = 1'b0;
    r.typed_status = ST_OK;
    return r;
  endfunction

  function automatic cmd_row_t row(logic [ACTION_BITS-1:0] a, logic [31:0] k, logic [31:0] ek,
                                   logic [31:0] v, bit t, status_t st);
    cmd_row_t r;
    r.action = a;
    r.key = k;
    r.end_key = ek;
    r.value = v;
    r.typed = t;
    r.typed_status = st;
    return r;
  endfunction

  // response side: random stalls, check at the rising edge
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      rsp_if.ready = 1'b0;
      recv_hold--;
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      recv_hold = draw_gap(recv_burst);
      if (pending_rsp.size() == 0) begin
        $error("unexpected item: status %0d key %h value %h", rsp_if.status,
               rsp_if.out_key, rsp_if.out_value);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.out_key !== want.out_key) begin
          $error("out_key: expected %h, got %h", want.out_key, rsp_if.out_key);
          error_count++;
        end
        if (rsp_if.out_value !== want.out_value) begin
          $error("out_value: expected %h, got %h", want.out_value, rsp_if.out_value);
          error_count++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_if.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    cmd_row_t directed [$];
    int limits [6];
    int sent;
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_PUT;
    cmd_if.key = '0;
    cmd_if.end_key = '0;
    cmd_if.value = '0;
    rsp_if.ready = 1'b0;
    shadow_count = 0;
    shadow_limit = MAX_ENTRIES_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(row(ACT_GET,    32'd5, 0, 0, 1, ST_MISS));
    directed.push_back(row(ACT_FLUSH,  0, 0, 0, 1, ST_MISS));
    directed.push_back(row(ACT_RANGE,  0, 32'hFFFF_FFFF, 0, 1, ST_MISS));
    directed.push_back(row(ACT_REMOVE, 32'd5, 0, 0, 1, ST_MISS));
    directed.push_back(row(ACT_PUT,    32'h0, 0, 32'hFFFF_FFFF, 1, ST_OK));
    directed.push_back(row(ACT_PUT,    32'hFFFF_FFFF, 0, 32'h0, 1, ST_OK));
    directed.push_back(row(ACT_PUT,    32'd7, 0, 32'd123, 1, ST_OK));
    directed.push_back(row(ACT_PUT,    32'd7, 0, 32'hA5A5_5A5A, 1, ST_OK));
    directed.push_back(row(ACT_GET,    32'd7, 0, 0, 0, ST_OK));
    directed.push_back(row(ACT_GET,    32'h0, 0, 0, 0, ST_OK));
    directed.push_back(row(ACT_GET,    32'hFFFF_FFFF, 0, 0, 0, ST_OK));
    directed.push_back(row(ACT_RANGE,  0, 32'hFFFF_FFFF, 0, 0, ST_OK));
    directed.push_back(row(ACT_RANGE,  32'd1, 32'd7, 0, 0, ST_OK));
    directed.push_back(row(ACT_RANGE,  32'd10, 32'd5, 0, 1, ST_MISS));
    directed.push_back(row(ACT_FLUSH,  0, 0, 0, 0, ST_OK));
    directed.push_back(row(ACT_UNUSED_LO, 32'd7, 0, 0, 0, ST_OK));
    directed.push_back(row(ACT_UNUSED_HI, 32'd7, 0, 0, 0, ST_OK));
    directed.push_back(row(ACT_REMOVE, 32'd7, 0, 0, 1, ST_OK));
    directed.push_back(row(ACT_GET,    32'd7, 0, 0, 1, ST_MISS));
    directed.push_back(row(ACT_CLEAR,  0, 0, 0, 1, ST_OK));
    directed.push_back(row(ACT_FLUSH,  0, 0, 0, 1, ST_MISS));
    foreach (directed[i]) send_cmd(directed[i]);

    // a single-entry limit: later puts are refused, even an overwrite of the stored key
    write_limit(1);
    send_cmd(row(ACT_PUT, 32'd9, 0, 32'd1, 1, ST_OK));
    send_cmd(row(ACT_PUT, 32'd3, 0, 32'd2, 1, ST_FULL));
    send_cmd(row(ACT_PUT, 32'd9, 0, 32'd3, 1, ST_FULL));

    limits = '{64, 5, 127, 0, 33, 64};
    sent = 0;
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int i = 0; i < 85; i++) begin
        cmd_row_t r;
        r = random_cmd();
        send_cmd(r);
        if (r.action != ACT_UNUSED_LO && r.action != ACT_UNUSED_HI) sent++;
        // hold off the sender until the buffer has answered everything
        if (i == 40) begin
          @(negedge clk);
          cmd_if.valid = 1'b0;
          while (pending_rsp.size() != 0) @(posedge clk);
        end
      end
    end
    drain();

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
